FILE: sv/pee_pkg.sv
package pee_pkg;

  localparam int unsigned StackDepthDefault = 64;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned SymWidth = 8;

  localparam logic [SymWidth-1:0] SymPow  = 8'h5E;
  localparam logic [SymWidth-1:0] SymMul  = 8'h2A;
  localparam logic [SymWidth-1:0] SymDiv  = 8'h2F;
  localparam logic [SymWidth-1:0] SymAdd  = 8'h2B;
  localparam logic [SymWidth-1:0] SymSub  = 8'h2D;
  localparam logic [SymWidth-1:0] SymZero = 8'h30;
  localparam logic [SymWidth-1:0] SymNine = 8'h39;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POP_B,
    ST_POP_A,
    ST_OP,
    ST_DIV,
    ST_POW_MUL,
    ST_POW_SQ,
    ST_PUSH,
    ST_TOP,
    ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_POW,
    OP_MUL,
    OP_DIV,
    OP_ADD,
    OP_SUB
  } op_e;

  typedef struct packed {
    logic [DataWidth-1:0] value;
    logic                 underflow;
    logic                 overflow;
    logic                 div_zero;
    logic                 empty_at_end;
  } result_t;

endpackage

FILE: sv/pee_if.sv
interface pee_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       last;
  modport source (output valid, symbol, last, input ready);
  modport sink (input valid, symbol, last, output ready);
endinterface

interface pee_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic        underflow;
  logic        overflow;
  logic        div_zero;
  logic        empty_at_end;
  modport source (output valid, value, underflow, overflow, div_zero, empty_at_end,
                  input ready);
  modport sink (input valid, value, underflow, overflow, div_zero, empty_at_end,
                output ready);
endinterface

FILE: sv/postfix_expression_evaluator_top.sv
// Channel | Dir | Payload                                          | Handshake
// in_i    | in  | symbol[7:0], last                                | valid/ready
// out_o   | out | value[31:0], underflow, overflow, div_zero,      | valid/ready
//         |     | empty_at_end                                     |
// One request at a time. A digit is accepted, then pushed. Any other character
// is accepted, then pops B and A through the single memory read port and goes
// to the operate state: +,-,*, a zero divisor and a negative exponent of ^ go
// on to one push, other characters do not push, / pushes after 32 radix-2
// restoring steps and ^ after up to 63 square-and-multiply steps. A last
// request then reads the top of stack (ST_TOP, ST_OUT). Reset clears count,
// flags and control only; the stack memory is never cleared. A result waits in
// its output register while out_o.ready is low; the next request is taken once
// it is gone.
module postfix_expression_evaluator_top import pee_pkg::*; #(
  parameter int unsigned StackDepth = StackDepthDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  pee_in_if.sink    in_i,
  pee_out_if.source out_o
);

  localparam int unsigned AW = (StackDepth > 1) ? $clog2(StackDepth) : 1;
  localparam int unsigned CW = $clog2(StackDepth + 1);
  localparam logic [CW-1:0] CntFull = CW'(StackDepth);

  // Stack memory: one write, one registered read.
  logic [DataWidth-1:0] mem_q [StackDepth];
  logic                 we;
  logic [AW-1:0]        waddr, raddr;
  logic [DataWidth-1:0] wdata, rdata_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  state_e state_q, state_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic                 unf_q, unf_d, ovf_q, ovf_d, dz_q, dz_d;
  logic                 last_q, last_d;
  op_e                  op_q, op_d;
  logic                 b_zero_q, b_zero_d;
  logic [DataWidth-1:0] a_q, a_d, b_q, b_d, res_q, res_d;
  logic [DataWidth-1:0] rem_q, rem_d;
  logic [5:0]           it_q, it_d;
  logic                 neg_q, neg_d;
  result_t              out_q, out_d;
  logic                 ov_q, ov_d;

  logic [DataWidth:0]   trial;
  logic [63:0]          prod;
  logic [DataWidth-1:0] mul_x, mul_y;

  assign in_i.ready = (state_q == ST_IDLE) && !ov_q;
  assign out_o.valid        = ov_q;
  assign out_o.value        = out_q.value;
  assign out_o.underflow    = out_q.underflow;
  assign out_o.overflow     = out_q.overflow;
  assign out_o.div_zero     = out_q.div_zero;
  assign out_o.empty_at_end = out_q.empty_at_end;

  assign prod  = mul_x * mul_y;
  assign trial = {rem_q, a_q[DataWidth-1]} - {1'b0, b_q};

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid && !ov_q) begin
          if (in_i.symbol inside {[SymZero:SymNine]}) begin
            state_d = ST_PUSH;
          end else begin
            state_d = ST_POP_B;
          end
        end
      end
      ST_POP_B: state_d = ST_POP_A;
      ST_POP_A: state_d = ST_OP;
      ST_OP: begin
        case (op_q)
          OP_NONE: state_d = last_q ? ST_TOP : ST_IDLE;
          OP_DIV:  state_d = b_zero_q ? ST_PUSH : ST_DIV;
          OP_POW:  state_d = b_q[DataWidth-1] ? ST_PUSH : ST_POW_MUL;
          default: state_d = ST_PUSH;
        endcase
      end
      ST_DIV:     state_d = (it_q == 6'd31) ? ST_PUSH : ST_DIV;
      ST_POW_MUL: state_d = (b_q == '0) ? ST_PUSH : ST_POW_SQ;
      ST_POW_SQ:  state_d = ST_POW_MUL;
      ST_PUSH:    state_d = last_q ? ST_TOP : ST_IDLE;
      ST_TOP:     state_d = ST_OUT;
      ST_OUT:     state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    cnt_d = cnt_q; unf_d = unf_q; ovf_d = ovf_q; dz_d = dz_q;
    last_d = last_q; op_d = op_q; a_d = a_q; b_d = b_q; res_d = res_q;
    rem_d = rem_q; it_d = it_q; neg_d = neg_q; out_d = out_q; ov_d = ov_q;
    b_zero_d = b_zero_q;
    we = 1'b0; waddr = cnt_q[AW-1:0]; wdata = res_q;
    raddr = AW'(cnt_q - CW'(1));
    mul_x = a_q; mul_y = b_q;
    if (ov_q && out_o.ready) begin
      ov_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid && !ov_q) begin
          last_d = in_i.last;
          res_d  = DataWidth'(in_i.symbol - SymZero);
          case (in_i.symbol)
            SymPow:  op_d = OP_POW;
            SymMul:  op_d = OP_MUL;
            SymDiv:  op_d = OP_DIV;
            SymAdd:  op_d = OP_ADD;
            SymSub:  op_d = OP_SUB;
            default: op_d = OP_NONE;
          endcase
          // Issue the read for B; a digit leaves the stack alone.
          if (!(in_i.symbol inside {[SymZero:SymNine]}) && cnt_q != '0) begin
            cnt_d = cnt_q - CW'(1);
          end
        end
      end
      ST_POP_B: begin
        // rdata_q is B if stack held anything; issue read for A.
        raddr = AW'(cnt_q - CW'(1));
        b_d = '0;
        // cnt_q was already decremented when B existed; track via it_q[5].
        if (it_q[5]) begin
          b_d = rdata_q;
        end else begin
          unf_d = 1'b1;
        end
        if (cnt_q != '0) begin
          cnt_d = cnt_q - CW'(1);
          it_d[4] = 1'b1;
        end else begin
          it_d[4] = 1'b0;
        end
      end
      ST_POP_A: begin
        a_d = '0;
        if (it_q[4]) begin
          a_d = rdata_q;
        end else begin
          unf_d = 1'b1;
        end
        b_zero_d = (b_q == '0);
      end
      ST_OP: begin
        case (op_q)
          OP_ADD: res_d = a_q + b_q;
          OP_SUB: res_d = a_q - b_q;
          OP_MUL: res_d = prod[DataWidth-1:0];
          OP_DIV: begin
            if (b_zero_q) begin
              dz_d = 1'b1; res_d = '0;
            end else begin
              neg_d = a_q[DataWidth-1] ^ b_q[DataWidth-1];
              a_d   = a_q[DataWidth-1] ? -a_q : a_q;
              b_d   = b_q[DataWidth-1] ? -b_q : b_q;
              rem_d = '0; it_d = '0;
            end
          end
          OP_POW: begin
            if (b_q[DataWidth-1]) begin
              if (a_q == '0) begin
                dz_d = 1'b1; res_d = '0;
              end else if (a_q == DataWidth'(1)) begin
                res_d = DataWidth'(1);
              end else if (a_q == '1) begin
                res_d = b_q[0] ? '1 : DataWidth'(1);
              end else begin
                res_d = '0;
              end
            end else begin
              res_d = DataWidth'(1);
            end
          end
          default: ;
        endcase
      end
      ST_DIV: begin
        // One restoring-division bit per cycle; a_q shifts out dividend bits
        // and collects quotient bits.
        if (!trial[DataWidth]) begin
          rem_d = trial[DataWidth-1:0];
          a_d   = {a_q[DataWidth-2:0], 1'b1};
        end else begin
          rem_d = {rem_q[DataWidth-2:0], a_q[DataWidth-1]};
          a_d   = {a_q[DataWidth-2:0], 1'b0};
        end
        it_d = it_q + 6'd1;
        if (it_q == 6'd31) begin
          res_d = neg_q ? -a_d : a_d;
        end
      end
      ST_POW_MUL: begin
        mul_x = res_q; mul_y = a_q;
        if (b_q[0]) begin
          res_d = prod[DataWidth-1:0];
        end
        b_d = b_q >> 1;
      end
      ST_POW_SQ: begin
        mul_x = a_q; mul_y = a_q;
        a_d = prod[DataWidth-1:0];
      end
      ST_PUSH: begin
        if (cnt_q == CntFull) begin
          ovf_d = 1'b1;
        end else begin
          we = 1'b1;
          cnt_d = cnt_q + CW'(1);
        end
      end
      ST_TOP: begin
        raddr = AW'(cnt_q - CW'(1));
      end
      ST_OUT: begin
        out_d.value        = (cnt_q != '0) ? rdata_q : '0;
        out_d.underflow    = unf_q;
        out_d.overflow     = ovf_q;
        out_d.div_zero     = dz_q;
        out_d.empty_at_end = (cnt_q == '0);
        ov_d  = 1'b1;
        cnt_d = '0; unf_d = 1'b0; ovf_d = 1'b0; dz_d = 1'b0;
      end
      default: ;
    endcase
    // Remember whether the B pop found a value.
    if (state_q == ST_IDLE && in_i.valid && !ov_q) begin
      it_d[5] = (cnt_q != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      unf_q   <= 1'b0;
      ovf_q   <= 1'b0;
      dz_q    <= 1'b0;
      ov_q    <= 1'b0;
      it_q    <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      unf_q   <= unf_d;
      ovf_q   <= ovf_d;
      dz_q    <= dz_d;
      ov_q    <= ov_d;
      it_q    <= it_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q   <= last_d;
    op_q     <= op_d;
    a_q      <= a_d;
    b_q      <= b_d;
    res_q    <= res_d;
    rem_q    <= rem_d;
    neg_q    <= neg_d;
    out_q    <= out_d;
    b_zero_q <= b_zero_d;
  end

endmodule
